@@ hdl/brfdo_pkg.sv @@
// Shared types, constants and helpers for the byte ring FIFO.
`timescale 1ns / 1ps
package brfdo_pkg;

    localparam int RING_DEPTH = 256 * 1024;
    localparam int MAX_PULL   = 64;

    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int PULL_W  = 7;
    localparam int LEVEL_W = 19;
    localparam int UNDER_W = 32;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > PULL_W) ? FILL_W : PULL_W;
    localparam int SUM_W  = ((ADDR_W > PULL_W) ? ADDR_W : PULL_W) + 1;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_STATUS,
        CMD_WRITE_STATUS,
        CMD_PULL
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE,
        BK_PULL
    } t_bk_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               full;
        logic [UNDER_W-1:0] under;
    } t_meta;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic [PULL_W-1:0]  count;
        t_meta              meta;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic              last;
        t_meta             meta;
    } t_res;

    function automatic logic [ADDR_W-1:0] f_advance(input logic [ADDR_W-1:0] pos);
        logic [ADDR_W-1:0] nxt;
        if (pos == ADDR_W'(RING_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = pos + ADDR_W'(1);
        end
        return nxt;
    endfunction

endpackage

@@ hdl/brfdo_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module brfdo_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/brfdo_front.sv @@
// Front end: accepts words, keeps ring positions and counters, queues commands.
`timescale 1ns / 1ps
module brfdo_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_data,
    input  logic                                  i_accept,
    input  logic [brfdo_pkg::OP_W-1:0]            i_operation,
    input  logic [brfdo_pkg::BYTE_W-1:0]          i_push_byte,
    input  logic                                  i_push_last,
    input  logic [brfdo_pkg::PULL_W-1:0]          i_pull_count,
    output logic                                  o_full,
    output logic                                  o_cmd_valid,
    output brfdo_pkg::t_cmd                       o_cmd,
    input  logic                                  i_cmd_pop
);

    logic                              r_enable;
    logic [brfdo_pkg::ADDR_W-1:0]      r_wr_pos;
    logic [brfdo_pkg::ADDR_W-1:0]      r_rd_pos;
    logic [brfdo_pkg::FILL_W-1:0]      r_fill;
    logic [brfdo_pkg::UNDER_W-1:0]     r_under;

    logic                              n_enable;
    logic [brfdo_pkg::ADDR_W-1:0]      n_wr_pos;
    logic [brfdo_pkg::ADDR_W-1:0]      n_rd_pos;
    logic [brfdo_pkg::FILL_W-1:0]      n_fill;
    logic [brfdo_pkg::UNDER_W-1:0]     n_under;

    brfdo_pkg::t_cmd                   r_q [brfdo_pkg::CQ_DEPTH];
    logic [brfdo_pkg::CQ_PTR_W-1:0]    r_q_wp;
    logic [brfdo_pkg::CQ_PTR_W-1:0]    r_q_rp;
    logic [brfdo_pkg::CQ_CNT_W-1:0]    r_q_cnt;

    brfdo_pkg::t_op                    op;
    logic                              at_cap;
    logic [brfdo_pkg::PULL_W-1:0]      req_sat;
    logic                              short_pull;
    logic [brfdo_pkg::PULL_W-1:0]      avail;
    logic [brfdo_pkg::SUM_W-1:0]       rd_sum;
    logic [brfdo_pkg::ADDR_W-1:0]      rd_wrap;
    logic                              cmd_load;
    brfdo_pkg::t_cmd                   cmd;

    assign op      = brfdo_pkg::t_op'(i_operation);
    assign at_cap  = (r_fill == brfdo_pkg::FILL_W'(brfdo_pkg::RING_DEPTH));
    assign req_sat = (i_pull_count > brfdo_pkg::PULL_W'(brfdo_pkg::MAX_PULL))
                     ? brfdo_pkg::PULL_W'(brfdo_pkg::MAX_PULL) : i_pull_count;
    assign short_pull = (brfdo_pkg::CMP_W'(r_fill) < brfdo_pkg::CMP_W'(req_sat));
    assign avail   = short_pull ? brfdo_pkg::PULL_W'(r_fill) : req_sat;
    assign rd_sum  = brfdo_pkg::SUM_W'(r_rd_pos) + brfdo_pkg::SUM_W'(avail);
    assign rd_wrap = (rd_sum >= brfdo_pkg::SUM_W'(brfdo_pkg::RING_DEPTH))
                     ? brfdo_pkg::ADDR_W'(rd_sum - brfdo_pkg::SUM_W'(brfdo_pkg::RING_DEPTH))
                     : brfdo_pkg::ADDR_W'(rd_sum);

    always_comb begin
        n_enable  = i_cfg_valid ? i_cfg_data : r_enable;
        n_wr_pos  = r_wr_pos;
        n_rd_pos  = r_rd_pos;
        n_fill    = r_fill;
        n_under   = r_under;
        cmd_load  = 1'b0;
        cmd.kind  = brfdo_pkg::CMD_WRITE;
        cmd.addr  = r_wr_pos;
        cmd.data  = i_push_byte;
        cmd.count = avail;
        if (i_accept) begin
            unique case (op)
                brfdo_pkg::OP_PUSH: begin
                    if (r_enable) begin
                        cmd_load = 1'b1;
                        cmd.kind = i_push_last ? brfdo_pkg::CMD_WRITE_STATUS
                                               : brfdo_pkg::CMD_WRITE;
                        n_wr_pos = brfdo_pkg::f_advance(r_wr_pos);
                        if (at_cap) begin
                            n_rd_pos = brfdo_pkg::f_advance(r_rd_pos);
                        end else begin
                            n_fill = r_fill + brfdo_pkg::FILL_W'(1);
                        end
                    end else if (i_push_last) begin
                        cmd_load = 1'b1;
                        cmd.kind = brfdo_pkg::CMD_STATUS;
                    end
                end
                brfdo_pkg::OP_PULL: begin
                    if (i_pull_count != '0) begin
                        cmd_load = 1'b1;
                        cmd.kind = (avail == '0) ? brfdo_pkg::CMD_STATUS
                                                 : brfdo_pkg::CMD_PULL;
                        cmd.addr = r_rd_pos;
                        n_rd_pos = rd_wrap;
                        n_fill   = r_fill - brfdo_pkg::FILL_W'(avail);
                        if (short_pull) begin
                            n_under = r_under + brfdo_pkg::UNDER_W'(1);
                        end
                    end
                end
                brfdo_pkg::OP_FLUSH: begin
                    n_wr_pos = '0;
                    n_rd_pos = '0;
                    n_fill   = '0;
                end
                brfdo_pkg::OP_CLEAR: begin
                    n_under = '0;
                end
                default: begin
                    n_under = r_under;
                end
            endcase
        end
        cmd.meta.level = brfdo_pkg::LEVEL_W'(n_fill);
        cmd.meta.full  = (n_fill == brfdo_pkg::FILL_W'(brfdo_pkg::RING_DEPTH));
        cmd.meta.under = n_under;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_fill   <= '0;
            r_under  <= '0;
        end else begin
            r_enable <= n_enable;
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_fill   <= n_fill;
            r_under  <= n_under;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_load) begin
            r_q[r_q_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (cmd_load) begin
                r_q_wp <= (r_q_wp == brfdo_pkg::CQ_PTR_W'(brfdo_pkg::CQ_DEPTH - 1))
                          ? '0 : r_q_wp + brfdo_pkg::CQ_PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_q_rp <= (r_q_rp == brfdo_pkg::CQ_PTR_W'(brfdo_pkg::CQ_DEPTH - 1))
                          ? '0 : r_q_rp + brfdo_pkg::CQ_PTR_W'(1);
            end
            r_q_cnt <= r_q_cnt + brfdo_pkg::CQ_CNT_W'(cmd_load)
                               - brfdo_pkg::CQ_CNT_W'(i_cmd_pop);
        end
    end

    assign o_full      = (r_q_cnt == brfdo_pkg::CQ_CNT_W'(brfdo_pkg::CQ_DEPTH));
    assign o_cmd_valid = (r_q_cnt != '0);
    assign o_cmd       = r_q[r_q_rp];

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= brfdo_pkg::FILL_W'(brfdo_pkg::RING_DEPTH))
        else $error("fill count above ring depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_q_cnt != '0))
        else $error("command popped from empty queue");
`endif

endmodule

@@ hdl/brfdo_back.sv @@
// Back end: executes commands against the ring memory and queues result words.
`timescale 1ns / 1ps
module brfdo_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  brfdo_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output brfdo_pkg::t_res o_res
);

    brfdo_pkg::t_bk_state             r_state;
    brfdo_pkg::t_bk_state             n_state;
    logic [brfdo_pkg::PULL_W-1:0]     r_cnt;
    logic [brfdo_pkg::ADDR_W-1:0]     r_addr;
    brfdo_pkg::t_meta                 r_meta;

    logic                             r_s1_valid;
    logic                             r_s1_ram;
    brfdo_pkg::t_res                  r_s1_res;

    brfdo_pkg::t_res                  r_oq [brfdo_pkg::OQ_DEPTH];
    logic [brfdo_pkg::OQ_PTR_W-1:0]   r_oq_wp;
    logic [brfdo_pkg::OQ_PTR_W-1:0]   r_oq_rp;
    logic [brfdo_pkg::OQ_CNT_W-1:0]   r_oq_cnt;

    logic                             room;
    logic                             cmd_pop;
    logic                             ram_we;
    logic                             issue;
    logic                             issue_ram;
    brfdo_pkg::t_res                  issue_res;
    logic [brfdo_pkg::BYTE_W-1:0]     ram_rdata;
    brfdo_pkg::t_res                  oq_in;
    logic                             oq_pop;
    logic                             last_byte;

    assign room = (brfdo_pkg::OQ_CNT_W'(r_oq_cnt) + brfdo_pkg::OQ_CNT_W'(r_s1_valid))
                  < brfdo_pkg::OQ_CNT_W'(brfdo_pkg::OQ_DEPTH);
    assign last_byte = (r_cnt == brfdo_pkg::PULL_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brfdo_pkg::BK_IDLE: begin
                if (i_cmd_valid && (i_cmd.kind == brfdo_pkg::CMD_PULL)) begin
                    n_state = brfdo_pkg::BK_PULL;
                end
            end
            brfdo_pkg::BK_PULL: begin
                if (room && last_byte) begin
                    n_state = brfdo_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = brfdo_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_pop              = 1'b0;
        ram_we               = 1'b0;
        issue                = 1'b0;
        issue_ram            = 1'b0;
        issue_res.read_byte  = '0;
        issue_res.byte_valid = 1'b0;
        issue_res.last       = 1'b1;
        issue_res.meta       = i_cmd.meta;
        unique case (r_state)
            brfdo_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        brfdo_pkg::CMD_WRITE: begin
                            cmd_pop = 1'b1;
                            ram_we  = 1'b1;
                        end
                        brfdo_pkg::CMD_WRITE_STATUS: begin
                            cmd_pop = room;
                            ram_we  = room;
                            issue   = room;
                        end
                        brfdo_pkg::CMD_STATUS: begin
                            cmd_pop = room;
                            issue   = room;
                        end
                        brfdo_pkg::CMD_PULL: begin
                            cmd_pop = 1'b1;
                        end
                        default: begin
                            cmd_pop = 1'b0;
                        end
                    endcase
                end
            end
            brfdo_pkg::BK_PULL: begin
                issue                = room;
                issue_ram            = 1'b1;
                issue_res.byte_valid = 1'b1;
                issue_res.last       = last_byte;
                issue_res.meta       = r_meta;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = cmd_pop;

    brfdo_ram #(
        .DATA_W (brfdo_pkg::BYTE_W),
        .DEPTH  (brfdo_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= brfdo_pkg::BK_IDLE;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            if (cmd_pop && (i_cmd.kind == brfdo_pkg::CMD_PULL)) begin
                r_cnt <= i_cmd.count;
            end else if (issue && issue_ram) begin
                r_cnt <= r_cnt - brfdo_pkg::PULL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_pop && (i_cmd.kind == brfdo_pkg::CMD_PULL)) begin
            r_addr <= i_cmd.addr;
            r_meta <= i_cmd.meta;
        end else if (issue && issue_ram) begin
            r_addr <= brfdo_pkg::f_advance(r_addr);
        end
        if (issue) begin
            r_s1_ram <= issue_ram;
            r_s1_res <= issue_res;
        end
    end

    always_comb begin
        oq_in = r_s1_res;
        if (r_s1_ram) begin
            oq_in.read_byte = ram_rdata;
        end
    end

    assign oq_pop = i_pop && (r_oq_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_oq_wp] <= oq_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_oq_wp <= (r_oq_wp == brfdo_pkg::OQ_PTR_W'(brfdo_pkg::OQ_DEPTH - 1))
                           ? '0 : r_oq_wp + brfdo_pkg::OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= (r_oq_rp == brfdo_pkg::OQ_PTR_W'(brfdo_pkg::OQ_DEPTH - 1))
                           ? '0 : r_oq_rp + brfdo_pkg::OQ_PTR_W'(1);
            end
            r_oq_cnt <= r_oq_cnt + brfdo_pkg::OQ_CNT_W'(r_s1_valid)
                                 - brfdo_pkg::OQ_CNT_W'(oq_pop);
        end
    end

    assign o_empty = (r_oq_cnt == '0);
    assign o_res   = r_oq[r_oq_rp];

`ifndef SYNTHESIS
    a_oq_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (brfdo_pkg::OQ_CNT_W'(r_oq_cnt) + brfdo_pkg::OQ_CNT_W'(r_s1_valid))
            <= brfdo_pkg::OQ_CNT_W'(brfdo_pkg::OQ_DEPTH))
        else $error("result queue overcommitted");

    a_pull_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfdo_pkg::BK_PULL) |-> (r_cnt != '0))
        else $error("pull state with no bytes left");
`endif

endmodule

@@ hdl/byte_ring_fifo_drop_oldest.sv @@
// Top level of the byte ring FIFO that drops the oldest byte when full.
//
// Input side is a queue write port: a word (operation, push_byte, push_last,
// pull_count) is taken when push is high and full is low. Result side is a
// queue read port: the oldest result word sits on the o_* fields while empty
// is low and leaves when pop is high. The enable register is written through
// i_cfg_valid / o_cfg_ready / i_cfg_data; o_cfg_ready is always high.
// The front end takes one word per cycle; full rises only when its
// four-entry command queue backs up. The back end retires a write command
// without waiting for room, a status command once the result queue has room,
// and a pull one ring memory read per byte while it has room; its single
// memory read port sets the pull rate. A status or empty-pull result passes
// the command queue, the stage-1 register and the result queue; the first
// pulled byte also passes a registered ring memory read, and the rest follow
// one per cycle while the result queue has room. Reset clears positions, fill
// count, underrun counter, the enable register and both queues; memory
// contents are kept and never cleared. A stalled reader fills the four-entry
// result queue, status and pull stall, the command queue fills, full rises.
`timescale 1ns / 1ps
module byte_ring_fifo_drop_oldest (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [brfdo_pkg::OP_W-1:0]          i_operation,
    input  logic [brfdo_pkg::BYTE_W-1:0]        i_push_byte,
    input  logic                                i_push_last,
    input  logic [brfdo_pkg::PULL_W-1:0]        i_pull_count,
    output logic                                empty,
    input  logic                                pop,
    output logic [brfdo_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                                o_byte_valid,
    output logic                                o_last_of_run,
    output logic [brfdo_pkg::LEVEL_W-1:0]       o_queued_level,
    output logic                                o_full_flag,
    output logic [brfdo_pkg::UNDER_W-1:0]       o_underrun_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);

    logic            accept;
    logic            cmd_valid;
    logic            cmd_pop;
    brfdo_pkg::t_cmd cmd;
    brfdo_pkg::t_res res;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    brfdo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_push_byte  (i_push_byte),
        .i_push_last  (i_push_last),
        .i_pull_count (i_pull_count),
        .o_full       (full),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    brfdo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_read_byte      = res.read_byte;
    assign o_byte_valid     = res.byte_valid;
    assign o_last_of_run    = res.last;
    assign o_queued_level   = res.meta.level;
    assign o_full_flag      = res.meta.full;
    assign o_underrun_total = res.meta.under;

endmodule
